### rtl/pia_pkg.sv
`timescale 1ns / 1ps

package pia_pkg;

    // Request codes
    localparam logic [2:0] REQ_READ    = 3'd0;
    localparam logic [2:0] REQ_WRITE   = 3'd1;
    localparam logic [2:0] REQ_PEEK    = 3'd2;
    localparam logic [2:0] REQ_CA1     = 3'd3;
    localparam logic [2:0] REQ_CA2     = 3'd4;
    localparam logic [2:0] REQ_CB1     = 3'd5;
    localparam logic [2:0] REQ_CB2     = 3'd6;

    // Port write report codes
    localparam logic [1:0] PW_NONE     = 2'd0;
    localparam logic [1:0] PW_PORT_A   = 2'd1;
    localparam logic [1:0] PW_PORT_B   = 2'd2;

    // Interrupt action codes
    localparam logic [1:0] IRQ_NONE    = 2'd0;
    localparam logic [1:0] IRQ_ASSERT  = 2'd1;
    localparam logic [1:0] IRQ_RELEASE = 2'd2;

    // Control register masks
    localparam logic [7:0] CR_FLAG_MASK = 8'hc0;
    localparam logic [7:0] CR_WR_MASK   = 8'h3f;

    // Architectural state of the adapter
    typedef struct packed {
        logic [7:0] ctrl_a;
        logic [7:0] ctrl_b;
        logic [7:0] latch_a;
        logic [7:0] latch_b;
        logic [7:0] dir_a;
        logic [7:0] dir_b;
        logic       line_ca2;
        logic       line_cb2;
        logic [7:0] drive_a;
        logic [7:0] drive_b;
    } pia_state_t;

    localparam pia_state_t PIA_STATE_RESET = '{
        ctrl_a:   8'h00,
        ctrl_b:   8'h00,
        latch_a:  8'h00,
        latch_b:  8'h00,
        dir_a:    8'h00,
        dir_b:    8'h00,
        line_ca2: 1'b1,
        line_cb2: 1'b1,
        drive_a:  8'hff,
        drive_b:  8'hff
    };

    // One accepted item
    typedef struct packed {
        logic [2:0] req_type;
        logic [1:0] addr;
        logic [7:0] wdata;
        logic       edge_rising;
        logic [7:0] pins_a;
        logic [7:0] pins_b;
    } pia_req_t;

    // One result item
    typedef struct packed {
        logic [7:0] rdata;
        logic [7:0] port_a_drive;
        logic [7:0] port_b_drive;
        logic [1:0] port_write;
        logic       ca2_level;
        logic       cb2_level;
        logic [1:0] cx2_pulsed;
        logic [1:0] irq_action;
    } pia_rsp_t;

endpackage

### rtl/pia_step.sv
`timescale 1ns / 1ps

module pia_step
    import pia_pkg::*;
(
    input  pia_state_t state_cur,
    input  pia_req_t   req,
    output pia_state_t state_upd,
    output pia_rsp_t   rsp
);

    // Pins merged with the latch by direction
    function automatic logic [7:0] merge_port(input logic [7:0] pins,
                                              input logic [7:0] latch,
                                              input logic [7:0] dir);
        merge_port = (pins & ~dir) | (latch & dir);
    endfunction

    // Register file read, no side effects
    function automatic logic [7:0] read_reg(input pia_state_t s,
                                            input logic [1:0] a,
                                            input logic [7:0] pa,
                                            input logic [7:0] pb);
        logic [7:0] v;
        if (a[1]) begin
            if (a[0])
                v = s.ctrl_b;
            else if (s.ctrl_b[2])
                v = merge_port(pb, s.latch_b, s.dir_b);
            else
                v = s.dir_b;
        end
        else begin
            if (a[0])
                v = s.ctrl_a;
            else if (s.ctrl_a[2])
                v = merge_port(pa, s.latch_a, s.dir_a);
            else
                v = s.dir_a;
        end
        read_reg = v;
    endfunction

    pia_state_t n;
    logic [7:0] rdata;
    logic [1:0] pwrite;
    logic [1:0] pulsed;
    logic [1:0] irq;
    logic       strobe;

    always_comb
    begin
        n      = state_cur;
        rdata  = 8'h00;
        pwrite = PW_NONE;
        pulsed = 2'b00;
        irq    = IRQ_NONE;
        strobe = 1'b0;

        unique case (req.req_type)
            REQ_READ:
            begin
                rdata = read_reg(state_cur, req.addr, req.pins_a, req.pins_b);
                // Data read: clear flags, release interrupt, A read strobe
                if (req.addr[1]) begin
                    if (!req.addr[0] && state_cur.ctrl_b[2]) begin
                        n.ctrl_b = state_cur.ctrl_b & CR_WR_MASK;
                        irq      = IRQ_RELEASE;
                    end
                end
                else if (!req.addr[0] && state_cur.ctrl_a[2]) begin
                    if (state_cur.ctrl_a[5:4] == 2'b10) begin
                        n.line_ca2 = state_cur.ctrl_a[3];
                        pulsed[0]  = state_cur.ctrl_a[3];
                    end
                    n.ctrl_a = state_cur.ctrl_a & CR_WR_MASK;
                    irq      = IRQ_RELEASE;
                end
            end
            REQ_WRITE:
            begin
                if (req.addr[1]) begin
                    if (req.addr[0]) begin
                        // Control B write
                        n.ctrl_b = (state_cur.ctrl_b & CR_FLAG_MASK)
                                 | (req.wdata & CR_WR_MASK);
                        if (req.wdata[5] && req.wdata[4])
                            n.line_cb2 = req.wdata[3];
                    end
                    else begin
                        // Port B data or direction write, write strobe
                        if (state_cur.ctrl_b[2]) begin
                            n.latch_b = req.wdata;
                            strobe    = (state_cur.ctrl_b[5:4] == 2'b10);
                        end
                        else begin
                            n.dir_b = req.wdata;
                        end
                        n.drive_b = n.latch_b | ~n.dir_b;
                        pwrite    = PW_PORT_B;
                        if (strobe) begin
                            n.line_cb2 = state_cur.ctrl_b[3];
                            pulsed[1]  = state_cur.ctrl_b[3];
                        end
                    end
                end
                else begin
                    if (req.addr[0]) begin
                        // Control A write
                        n.ctrl_a = (state_cur.ctrl_a & CR_FLAG_MASK)
                                 | (req.wdata & CR_WR_MASK);
                        if (req.wdata[5] && req.wdata[4])
                            n.line_ca2 = req.wdata[3];
                    end
                    else begin
                        // Port A data or direction write
                        if (state_cur.ctrl_a[2])
                            n.latch_a = req.wdata;
                        else
                            n.dir_a = req.wdata;
                        n.drive_a = n.latch_a | ~n.dir_a;
                        pwrite    = PW_PORT_A;
                    end
                end
            end
            REQ_PEEK:
            begin
                rdata = read_reg(state_cur, req.addr, req.pins_a, req.pins_b);
            end
            REQ_CA1:
            begin
                // Active edge sets flag, ends handshake
                if (req.edge_rising == state_cur.ctrl_a[1]) begin
                    if (state_cur.ctrl_a[5:3] == 3'b100)
                        n.line_ca2 = 1'b1;
                    n.ctrl_a[7] = 1'b1;
                    if (state_cur.ctrl_a[0])
                        irq = IRQ_ASSERT;
                end
            end
            REQ_CB1:
            begin
                if (req.edge_rising == state_cur.ctrl_b[1]) begin
                    if (state_cur.ctrl_b[5:3] == 3'b100)
                        n.line_cb2 = 1'b1;
                    n.ctrl_b[7] = 1'b1;
                    if (state_cur.ctrl_b[0])
                        irq = IRQ_ASSERT;
                end
            end
            REQ_CA2:
            begin
                // Only when CA2 is an input
                if (!state_cur.ctrl_a[5] && req.edge_rising == state_cur.ctrl_a[4]) begin
                    n.ctrl_a[6] = 1'b1;
                    if (state_cur.ctrl_a[3])
                        irq = IRQ_ASSERT;
                end
            end
            REQ_CB2:
            begin
                if (!state_cur.ctrl_b[5] && req.edge_rising == state_cur.ctrl_b[4]) begin
                    n.ctrl_b[6] = 1'b1;
                    if (state_cur.ctrl_b[3])
                        irq = IRQ_ASSERT;
                end
            end
            default:
            begin
                // unused request code: no-op
            end
        endcase
    end

    assign state_upd = n;

    // Result item from the updated state
    always_comb
    begin
        rsp.rdata        = rdata;
        rsp.port_a_drive = n.drive_a;
        rsp.port_b_drive = n.drive_b;
        rsp.port_write   = pwrite;
        rsp.ca2_level    = n.line_ca2;
        rsp.cb2_level    = n.line_cb2;
        rsp.cx2_pulsed   = pulsed;
        rsp.irq_action   = irq;
    end

endmodule

### rtl/peripheral_interface_adapter.sv
`timescale 1ns / 1ps

// Two-port parallel interface adapter with a valid/stall request channel and
// a valid/stall result channel. Each request item is a bus read, bus write,
// peek, or an edge event on CA1, CA2, CB1 or CB2; each yields one result item
// carrying read data, the driven port values, CA2/CB2 levels, strobe pulses
// and the interrupt action.
// An item is captured in the input register, evaluated by shallow logic
// against the register state and written to the result register when it
// advances. Throughput is one item per cycle while the receiver does not
// stall; the state update of one item is visible to the next item in the
// following cycle, so items stream back to back.
// When the receiver stalls, the result register holds its item; the next
// item waits in the input register and req_stall rises only once both are
// full, so at most two items are in flight.
// Reset clears control and data registers, sets CA2/CB2 high and both
// port drives to 0xff, and empties both pipeline registers.
module peripheral_interface_adapter
    import pia_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [2:0] req_type,
    input  logic [1:0] addr,
    input  logic [7:0] wdata,
    input  logic       edge_rising,
    input  logic [7:0] pins_a,
    input  logic [7:0] pins_b,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [7:0] rdata,
    output logic [7:0] port_a_drive,
    output logic [7:0] port_b_drive,
    output logic [1:0] port_write,
    output logic       ca2_level,
    output logic       cb2_level,
    output logic [1:0] cx2_pulsed,
    output logic [1:0] irq_action
);

    pia_state_t state_reg;
    pia_state_t state_next;
    pia_req_t   req_reg;
    logic       req_valid_reg;
    pia_rsp_t   rsp_reg;
    pia_rsp_t   rsp_next;
    logic       rsp_valid_reg;
    logic       advance;
    logic       req_take;

    // Pipeline control
    assign advance   = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    pia_step u_step (
        .state_cur (state_reg),
        .req       (req_reg),
        .state_upd (state_next),
        .rsp       (rsp_next)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid_reg <= 1'b0;
        end
        else if (req_take) begin
            req_valid_reg <= 1'b1;
        end
        else if (advance) begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take) begin
            req_reg.req_type    <= req_type;
            req_reg.addr        <= addr;
            req_reg.wdata       <= wdata;
            req_reg.edge_rising <= edge_rising;
            req_reg.pins_a      <= pins_a;
            req_reg.pins_b      <= pins_b;
        end
    end

    // Adapter state commits as the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= PIA_STATE_RESET;
        end
        else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance) begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign rdata        = rsp_reg.rdata;
    assign port_a_drive = rsp_reg.port_a_drive;
    assign port_b_drive = rsp_reg.port_b_drive;
    assign port_write   = rsp_reg.port_write;
    assign ca2_level    = rsp_reg.ca2_level;
    assign cb2_level    = rsp_reg.cb2_level;
    assign cx2_pulsed   = rsp_reg.cx2_pulsed;
    assign irq_action   = rsp_reg.irq_action;

`ifndef SYNTH
    // Drive values always track latch and direction
    a_drive_a_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.drive_a == (state_reg.latch_a | ~state_reg.dir_a))
        else $error("port A drive out of step with latch and direction");

    a_drive_b_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.drive_b == (state_reg.latch_b | ~state_reg.dir_b))
        else $error("port B drive out of step with latch and direction");

    // A pulsed strobe ends with the line high
    a_pulse_ends_high: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((!rsp_reg.cx2_pulsed[0] || rsp_reg.ca2_level)
                        && (!rsp_reg.cx2_pulsed[1] || rsp_reg.cb2_level)))
        else $error("strobe pulse reported but line left low");

    // A result item reports one port at most and a legal interrupt action
    a_one_port_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.port_write != 2'd3 && rsp_reg.irq_action != 2'd3))
        else $error("illegal port write or interrupt code");
`endif

endmodule
